// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the vertex transform RTL. Define
// NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define ASSERT_SAME(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/fpavt_pkg.sv
// ----------------------------------------------------------------------------
// fpavt_pkg
// Types and constants of the fixed-point affine vertex transform.
// ----------------------------------------------------------------------------
package fpavt_pkg;

  localparam int MAT_ROWS  = 3;
  localparam int MAT_COLS  = 4;
  localparam int VEC_COMPS = 3;
  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 16;

  // Translation column of each row
  localparam logic [1:0] COL_TRANS = 2'd3;

  // Operation codes carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  // Stream widths
  localparam int S_TDATA_W = 136;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 96;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [MAT_COLS-1:0]     row_t;
  typedef logic [1:0]               idx_t;

  // Pipeline control shared between the merge stage and the lanes
  typedef struct packed {
    logic advance;
    logic stage_valid;
  } pipe_ctrl_t;

endpackage

// File: src/fixed_point_affine_vertex_transform.sv
// ----------------------------------------------------------------------------
// fixed_point_affine_vertex_transform
// Transforms signed 16.16 vectors by a stored 3x4 affine matrix. Items with
// operation 0 in tuser write one matrix entry (row 3 is ignored) and give no
// result; items with operation 1 give one result each. One item is taken
// every cycle while the output side keeps up; each result passes through the
// registered multipliers of the three row lanes and then the output register
// fed by the lane adders. The matrix resets to all zero at once, with no
// clearing pass. A write followed at once by a transform uses the new entry.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_point_affine_vertex_transform (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // entry_row[1:0], entry_col[3:2], entry_value[35:4], vec_x[67:36],
  // vec_y[99:68], vec_z[131:100], zero fill[135:132]
  input  logic [fpavt_pkg::S_TDATA_W-1:0]     s_tdata,
  // operation[0]
  input  logic [fpavt_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [fpavt_pkg::M_TDATA_W-1:0]     m_tdata
);
  import fpavt_pkg::*;

  idx_t       entry_row;
  idx_t       entry_col;
  word_t      entry_value;
  word_t      vec [VEC_COMPS];
  logic       operation;
  logic       in_fire;
  row_t       rows [MAT_ROWS];
  word_t      sums [MAT_ROWS];
  pipe_ctrl_t ctrl;

  // Unpack the input item
  assign entry_row   = s_tdata[1:0];
  assign entry_col   = s_tdata[3:2];
  assign entry_value = s_tdata[35:4];
  assign vec[0]      = s_tdata[67:36];
  assign vec[1]      = s_tdata[99:68];
  assign vec[2]      = s_tdata[131:100];
  assign operation   = s_tuser[0];

  assign s_tready = ctrl.advance;
  assign in_fire  = s_tvalid && s_tready;

  // Matrix store
  fpavt_matrix u_matrix (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_fire && (operation == OP_WRITE)),
    .wr_row   (entry_row),
    .wr_col   (entry_col),
    .wr_value (entry_value),
    .rows     (rows)
  );

  // One lane per output component
  for (genvar r = 0; r < MAT_ROWS; r++) begin : g_lane
    fpavt_lane u_lane (
      .clk    (clk),
      .enable (ctrl.advance),
      .row    (rows[r]),
      .vec    (vec),
      .sum    (sums[r])
    );
  end

  // Result assembly and output register
  fpavt_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_xform (s_tvalid && (operation == OP_XFORM)),
    .sums     (sums),
    .ctrl     (ctrl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A transform item always fills the product stage
  `ASSERT_NEXT(a_xform_fills_stage, clk, rst, in_fire && (operation == OP_XFORM), ctrl.stage_valid, "transform item lost before product stage")

  // A write item never creates work in the product stage
  `ASSERT_NEXT(a_write_no_result, clk, rst, in_fire && (operation == OP_WRITE), !ctrl.stage_valid, "write item produced a result")

  // A new result only comes from a filled product stage
  `ASSERT_SAME(a_result_from_stage, clk, rst, $rose(m_tvalid), $past(ctrl.stage_valid), "result invented without a product stage item")

endmodule

// File: src/fpavt_matrix.sv
// ----------------------------------------------------------------------------
// fpavt_matrix
// Holds the 3x4 affine matrix; one entry is written per write item.
// ----------------------------------------------------------------------------
module fpavt_matrix (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  fpavt_pkg::idx_t   wr_row,
  input  fpavt_pkg::idx_t   wr_col,
  input  fpavt_pkg::word_t  wr_value,
  output fpavt_pkg::row_t   rows [fpavt_pkg::MAT_ROWS]
);
  import fpavt_pkg::*;

  row_t mat [MAT_ROWS];

  // Write one entry; a write to the missing fourth row is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAT_ROWS; r++) begin
        mat[r] <= '0;
      end
    end else if (wr_en) begin
      for (int r = 0; r < MAT_ROWS; r++) begin
        if (wr_row == idx_t'(r)) begin
          mat[r][wr_col] <= wr_value;
        end
      end
    end
  end

  assign rows = mat;

endmodule

// File: src/fpavt_lane.sv
// ----------------------------------------------------------------------------
// fpavt_lane
// One output component: three 16.16 products registered, then summed with
// the translation entry.
// ----------------------------------------------------------------------------
module fpavt_lane (
  input  logic              clk,
  input  logic              enable,
  input  fpavt_pkg::row_t   row,
  input  fpavt_pkg::word_t  vec [fpavt_pkg::VEC_COMPS],
  output fpavt_pkg::word_t  sum
);
  import fpavt_pkg::*;

  logic signed [2*WORD_W-1:0] full [VEC_COMPS];
  word_t                      prod [VEC_COMPS];
  word_t                      trans;

  // Full signed products of the row against the vector
  always_comb begin
    for (int c = 0; c < VEC_COMPS; c++) begin
      full[c] = row[c] * vec[c];
    end
  end

  // Keep bits 16..47 of each product and capture translation with them
  always_ff @(posedge clk) begin
    if (enable) begin
      for (int c = 0; c < VEC_COMPS; c++) begin
        prod[c] <= full[c][FRAC_W+WORD_W-1:FRAC_W];
      end
      trans <= row[COL_TRANS];
    end
  end

  // Sum wraps modulo 2^32
  assign sum = prod[0] + prod[1] + prod[2] + trans;

endmodule

// File: src/fpavt_merge.sv
// ----------------------------------------------------------------------------
// fpavt_merge
// Gathers the lane sums into one result item and holds it in the output
// register; drives the pipeline advance.
// ----------------------------------------------------------------------------
module fpavt_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_xform,
  input  fpavt_pkg::word_t                  sums [fpavt_pkg::MAT_ROWS],
  output fpavt_pkg::pipe_ctrl_t             ctrl,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [fpavt_pkg::M_TDATA_W-1:0]   m_tdata
);
  import fpavt_pkg::*;

  logic stage_valid;
  logic out_valid;
  logic out_free;
  logic [M_TDATA_W-1:0] out_data;

  assign out_free     = !out_valid || m_tready;
  assign ctrl.advance = !stage_valid || out_free;
  assign ctrl.stage_valid = stage_valid;

  // Advance the product stage and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (ctrl.advance) begin
        stage_valid <= in_xform;
      end
      if (out_free) begin
        out_valid <= stage_valid;
      end
    end
  end

  // Pack out_x, out_y, out_z from the lowest bits up
  always_ff @(posedge clk) begin
    if (out_free && stage_valid) begin
      for (int r = 0; r < MAT_ROWS; r++) begin
        out_data[r*WORD_W +: WORD_W] <= sums[r];
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
